FILE: rtl/core/cesd_pkg.sv
// Package for the C escape string decoder.
// Holds the phase type, the queued run type, character constants and decode functions.
// No dependencies.
package cesd_pkg;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_BSL   = 2'd1,
		PH_X     = 2'd2,
		PH_X1    = 2'd3
	} phase_t;

	localparam int unsigned RUN_MAX = 4;
	localparam int unsigned RUN_IW  = $clog2(RUN_MAX);

	// up to four decoded bytes from one request
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [RUN_IW-1:0]       last_idx;
		logic                    str_end;
	} run_t;

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// {hit, character}
	function automatic logic [8:0] simple_esc(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			8'h3F: r = {1'b1, 8'h3F};
			8'h5C: r = {1'b1, 8'h5C};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h76: r = {1'b1, 8'h0B};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/c_escape_string_decoder.sv
// C escape string decoder top level: front end, run queue, back end.
// Data path: each decoded byte is held in the run queue and then in the back end output register.
// Throughput: one request per cycle while the run queue has room; one output byte per
// cycle from the back end while the queue holds a run and the output is not stalled.
// Reset: arst_n clears escape phase, queue pointers and output valid asynchronously.
module c_escape_string_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done
);

	cesd_pkg::run_t wr_run, rd_run;
	logic           q_push, q_pop, q_full, q_empty;

	cesd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.string_end (string_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_run      (wr_run)
	);

	cesd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_run (wr_run),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_run (rd_run)
	);

	cesd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_run       (rd_run),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule

FILE: rtl/core/cesd_front.sv
// Front end: accepts escaped bytes, tracks escape phase and builds output runs.
// Depends on cesd_pkg.
module cesd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               string_end,
	input  logic               q_full,
	output logic               q_push,
	output cesd_pkg::run_t     q_run
);

	cesd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       fhc_q, fhc_d;
	logic [2:0]       cnt;
	logic [8:0]       se;
	logic [4:0]       hi, lo;
	logic [7:0]       hv;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cesd_pkg::PH_PLAIN;
			fhc_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			fhc_q   <= fhc_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		fhc_d   = fhc_q;
		q_run   = '0;
		cnt     = 3'd0;
		se      = cesd_pkg::simple_esc(in_byte);
		hi      = cesd_pkg::hex_nib(fhc_q);
		lo      = cesd_pkg::hex_nib(in_byte);
		hv      = {hi[3:0], lo[3:0]};
		case (phase_q)
			cesd_pkg::PH_PLAIN: begin
				if (in_byte == cesd_pkg::CH_BSL) begin
					phase_d = cesd_pkg::PH_BSL;
				end else begin
					q_run.bytes[0] = in_byte;
					cnt = 3'd1;
				end
			end
			cesd_pkg::PH_BSL: begin
				if (in_byte == cesd_pkg::CH_X) begin
					phase_d = cesd_pkg::PH_X;
				end else if (se[8]) begin
					q_run.bytes[0] = se[7:0];
					cnt = 3'd1;
					phase_d = cesd_pkg::PH_PLAIN;
				end else begin
					q_run.bytes[0] = cesd_pkg::CH_BSL;
					q_run.bytes[1] = in_byte;
					cnt = 3'd2;
					phase_d = cesd_pkg::PH_PLAIN;
				end
			end
			cesd_pkg::PH_X: begin
				fhc_d = in_byte;
				phase_d = cesd_pkg::PH_X1;
			end
			cesd_pkg::PH_X1: begin
				if (hi[4] && lo[4]) begin
					if (hv == 8'd0) begin
						q_run.bytes[0] = cesd_pkg::CH_BSL;
						q_run.bytes[1] = cesd_pkg::CH_ZERO;
						cnt = 3'd2;
					end else begin
						q_run.bytes[0] = hv;
						cnt = 3'd1;
					end
				end else begin
					q_run.bytes[0] = cesd_pkg::CH_BSL;
					q_run.bytes[1] = cesd_pkg::CH_X;
					q_run.bytes[2] = fhc_q;
					q_run.bytes[3] = in_byte;
					cnt = 3'd4;
				end
				phase_d = cesd_pkg::PH_PLAIN;
			end
			default: phase_d = cesd_pkg::PH_PLAIN;
		endcase
		// flush of an open escape; nothing was emitted on these paths
		if (string_end) begin
			case (phase_d)
				cesd_pkg::PH_BSL: begin
					q_run.bytes[0] = cesd_pkg::CH_BSL;
					cnt = 3'd1;
				end
				cesd_pkg::PH_X: begin
					q_run.bytes[0] = cesd_pkg::CH_BSL;
					q_run.bytes[1] = cesd_pkg::CH_X;
					cnt = 3'd2;
				end
				cesd_pkg::PH_X1: begin
					q_run.bytes[0] = cesd_pkg::CH_BSL;
					q_run.bytes[1] = cesd_pkg::CH_X;
					q_run.bytes[2] = in_byte;
					cnt = 3'd3;
				end
				default: ;
			endcase
			phase_d = cesd_pkg::PH_PLAIN;
		end
		q_run.last_idx = cnt[1:0] - 2'd1;
		q_run.str_end  = string_end;
	end

endmodule

FILE: rtl/core/cesd_queue.sv
// Run queue between front and back end of the decoder.
// Depends on cesd_pkg.
module cesd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cesd_pkg::run_t wr_run,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output cesd_pkg::run_t rd_run
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cesd_pkg::run_t    mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [CW-1:0]     cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_run = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cesd_back.sv
// Back end: unrolls queued runs to an output register, one byte per cycle unless stalled.
// Depends on cesd_pkg.
module cesd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  cesd_pkg::run_t q_run,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           run_last,
	output logic           string_done
);

	logic [cesd_pkg::RUN_IW-1:0] idx_q;
	logic                        vld_q;
	logic [7:0]                  byte_q;
	logic                        last_q, done_q;
	logic                        load, last;

	assign load  = !q_empty && (!vld_q || out_ready);
	assign last  = (idx_q == q_run.last_idx);
	assign q_pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= last ? '0 : idx_q + 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_run.bytes[idx_q];
			last_q <= last;
			done_q <= last && q_run.str_end;
		end
	end

	assign out_valid   = vld_q;
	assign out_byte    = byte_q;
	assign run_last    = last_q;
	assign string_done = done_q;

endmodule

FILE: rtl/core/cesd_checker.sv
// Port-level checker for the C escape string decoder, bound to the top level.
// Depends only on the top-level ports.
module cesd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       string_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(string_done))
		else $error("output request changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> run_last)
		else $error("string end not on last byte of its run");

	a_rst_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind c_escape_string_decoder cesd_checker u_cesd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.run_last    (run_last),
	.string_done (string_done)
);
